/* design/jsf_pkg.sv */
// ---------------------------------------------------------------------------
// jsf_pkg
// Shared types and constants for the JSON object stream framer.
// ---------------------------------------------------------------------------
package jsf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 20;
  localparam int unsigned NestW  = 8;

  localparam logic [LenW-1:0] LenReset = {LenW{1'b1}};

  localparam logic [ByteW-1:0] ChOpen   = 8'h7B;
  localparam logic [ByteW-1:0] ChClose  = 8'h7D;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;

  typedef enum logic [1:0] {
    KIND_DROP   = 2'd0,
    KIND_OBJ    = 2'd1,
    KIND_OVF    = 2'd2,
    KIND_CLOSED = 2'd3
  } kind_t;

  typedef struct packed {
    logic             inside_object;
    logic             inside_string;
    logic             escape_pending;
    logic [NestW-1:0] nesting_level;
    logic [LenW-1:0]  object_byte_count;
    logic             stream_closed;
  } frame_state_t;

  typedef struct packed {
    kind_t kind;
    logic  first_of_object;
    logic  last_of_object;
  } byte_tag_t;

endpackage

/* design/json_object_stream_framer.sv */
// ---------------------------------------------------------------------------
// json_object_stream_framer
// Delimits top-level JSON objects in a byte stream, one tag per byte.
// ---------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel; tdata carries the byte and tuser the
//   new-connection flag, which clears all framing state before that byte.
//   Every byte gives exactly one transaction on m_axis: the byte itself in
//   tdata, the kind (dropped, object byte, overflow, discarded after close)
//   and the first-of-object flag in tuser, and tlast on the closing brace
//   of an object.
//   The result appears in the cycle after the input transaction. Throughput
//   is one byte per cycle while unstalled: framing state and result register
//   are both updated in the accepting cycle by a single pass of short logic.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops; a new byte is taken in the same cycle the held result leaves.
//   Reset clears the framing state and the output valid, and sets the
//   length limit to its largest value. Write the limit through cfg_wr_en /
//   cfg_wr_data only while no transaction is in flight.
// ---------------------------------------------------------------------------
module json_object_stream_framer #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [jsf_pkg::LenW-1:0]    cfg_wr_data,   // max_object_length
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  logic                        s_axis_tuser,  // [0] new_connection
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                  m_axis_tuser,  // [1:0] kind, [2] first_of_object
  output logic                        m_axis_tlast   // last_of_object
);

  jsf_pkg::frame_state_t       state;
  jsf_pkg::frame_state_t       state_next;
  jsf_pkg::byte_tag_t          tag;
  logic [jsf_pkg::LenW-1:0]    max_object_length;
  logic                        accept;

  jsf_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .state             (state),
    .data_byte         (s_axis_tdata),
    .new_connection    (s_axis_tuser),
    .max_object_length (max_object_length),
    .state_next        (state_next),
    .tag               (tag)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_object_length <= jsf_pkg::LenReset;
    end else if (cfg_wr_en) begin
      max_object_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state         <= state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= s_axis_tdata;
      m_axis_tuser <= {tag.first_of_object, tag.kind};
      m_axis_tlast <= tag.last_of_object;
    end
  end

endmodule

/* design/jsf_step.sv */
// ---------------------------------------------------------------------------
// jsf_step
// Per-byte framing update: classifies one byte and computes the next state.
// ---------------------------------------------------------------------------
module jsf_step #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  jsf_pkg::frame_state_t           state,
  input  logic [jsf_pkg::ByteW-1:0]       data_byte,
  input  logic                            new_connection,
  input  logic [jsf_pkg::LenW-1:0]        max_object_length,
  output jsf_pkg::frame_state_t           state_next,
  output jsf_pkg::byte_tag_t              tag
);

  localparam logic [jsf_pkg::NestW-1:0] DepthLimit = jsf_pkg::NestW'(MAX_DEPTH);

  jsf_pkg::frame_state_t  cur;
  logic [jsf_pkg::LenW:0] count_inc;

  always_comb begin
    // a new connection clears everything, closed flag included
    cur = new_connection ? '0 : state;
    count_inc = {1'b0, cur.object_byte_count} + 1'b1;

    state_next = cur;
    tag.kind = jsf_pkg::KIND_DROP;
    tag.first_of_object = 1'b0;
    tag.last_of_object = 1'b0;

    if (cur.stream_closed) begin
      tag.kind = jsf_pkg::KIND_CLOSED;
    end else if (!cur.inside_object) begin
      if (data_byte == jsf_pkg::ChOpen) begin
        if (max_object_length == '0) begin
          state_next = '0;
          state_next.stream_closed = 1'b1;
          tag.kind = jsf_pkg::KIND_OVF;
        end else begin
          state_next.inside_object = 1'b1;
          state_next.inside_string = 1'b0;
          state_next.escape_pending = 1'b0;
          state_next.nesting_level = jsf_pkg::NestW'(1);
          state_next.object_byte_count = jsf_pkg::LenW'(1);
          tag.kind = jsf_pkg::KIND_OBJ;
          tag.first_of_object = 1'b1;
        end
      end
    end else if (count_inc > {1'b0, max_object_length}) begin
      state_next = '0;
      state_next.stream_closed = 1'b1;
      tag.kind = jsf_pkg::KIND_OVF;
    end else if (cur.inside_string) begin
      state_next.object_byte_count = count_inc[jsf_pkg::LenW-1:0];
      tag.kind = jsf_pkg::KIND_OBJ;
      if (cur.escape_pending) begin
        state_next.escape_pending = 1'b0;
      end else if (data_byte == jsf_pkg::ChBslash) begin
        state_next.escape_pending = 1'b1;
      end else if (data_byte == jsf_pkg::ChQuote) begin
        state_next.inside_string = 1'b0;
      end
    end else if (data_byte == jsf_pkg::ChOpen && cur.nesting_level >= DepthLimit) begin
      state_next = '0;
      state_next.stream_closed = 1'b1;
      tag.kind = jsf_pkg::KIND_OVF;
    end else begin
      state_next.object_byte_count = count_inc[jsf_pkg::LenW-1:0];
      tag.kind = jsf_pkg::KIND_OBJ;
      if (data_byte == jsf_pkg::ChQuote) begin
        state_next.inside_string = 1'b1;
      end else if (data_byte == jsf_pkg::ChOpen) begin
        state_next.nesting_level = cur.nesting_level + 1'b1;
      end else if (data_byte == jsf_pkg::ChClose) begin
        if (cur.nesting_level == jsf_pkg::NestW'(1)) begin
          // outermost brace closes: drop all object state
          state_next = '0;
          tag.last_of_object = 1'b1;
        end else begin
          state_next.nesting_level = cur.nesting_level - 1'b1;
        end
      end
    end
  end

endmodule

/* sim/tb_json_object_stream_framer.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_json_object_stream_framer
// Self-checking testbench for the JSON object stream framer. Bytes are driven
// on the s_axis channel with random gaps, and results are taken on m_axis
// under random back-pressure. A predictor of the framing state works out the
// tag for every accepted byte. A checker compares each result transaction
// against the oldest pending tag. Directed tests cover basic framing,
// strings and escapes, the length limit and the nesting limit. Random traffic
// then runs under several length limits.
// ---------------------------------------------------------------------------
module tb_json_object_stream_framer;

  localparam int unsigned NestMax = 255;

  typedef struct packed {
    logic [jsf_pkg::ByteW-1:0] data;
    jsf_pkg::kind_t            kind;
    logic                      first;
    logic                      last;
  } byte_tag_exp_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [jsf_pkg::LenW-1:0]  cfg_wr_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;   // [7:0] data_byte
  logic                      s_axis_tuser = 1'b0; // [0] new_connection
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;        // [7:0] out_byte
  logic [2:0]                m_axis_tuser;        // [1:0] kind, [2] first_of_object
  logic                      m_axis_tlast;        // last_of_object

  // Predictor state, advanced once per accepted byte
  jsf_pkg::frame_state_t     frame;
  logic [jsf_pkg::LenW-1:0]  len_limit;
  byte_tag_exp_t             expected_tags[$];

  bit               no_idle = 1'b0;
  int               stall_left = 0;
  int               error_count = 0;
  int               bytes_sent = 0;
  int               tags_checked = 0;
  int               objects_closed = 0;
  int               overflow_aborts = 0;
  int               limit_writes = 0;

  json_object_stream_framer #(.MAX_DEPTH(NestMax)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the framing state by one byte and return the tag it should get
  function automatic byte_tag_exp_t predict_tag(input logic [jsf_pkg::ByteW-1:0] b,
                                                input logic nc);
    byte_tag_exp_t t;
    logic [jsf_pkg::LenW:0] next_len;
    t.data  = b;
    t.kind  = jsf_pkg::KIND_DROP;
    t.first = 1'b0;
    t.last  = 1'b0;
    if (nc) frame = '0;
    next_len = {1'b0, frame.object_byte_count} + 1'b1;
    if (frame.stream_closed) begin
      t.kind = jsf_pkg::KIND_CLOSED;
    end else if (!frame.inside_object) begin
      if (b == jsf_pkg::ChOpen) begin
        if (len_limit == '0) begin
          frame = '0;
          frame.stream_closed = 1'b1;
          t.kind = jsf_pkg::KIND_OVF;
        end else begin
          frame.inside_object     = 1'b1;
          frame.nesting_level     = jsf_pkg::NestW'(1);
          frame.object_byte_count = jsf_pkg::LenW'(1);
          t.kind  = jsf_pkg::KIND_OBJ;
          t.first = 1'b1;
        end
      end
    end else if (next_len > {1'b0, len_limit}) begin
      frame = '0;
      frame.stream_closed = 1'b1;
      t.kind = jsf_pkg::KIND_OVF;
    end else if (frame.inside_string) begin
      frame.object_byte_count = next_len[jsf_pkg::LenW-1:0];
      t.kind = jsf_pkg::KIND_OBJ;
      if (frame.escape_pending) frame.escape_pending = 1'b0;
      else if (b == jsf_pkg::ChBslash) frame.escape_pending = 1'b1;
      else if (b == jsf_pkg::ChQuote) frame.inside_string = 1'b0;
    end else if (b == jsf_pkg::ChOpen && frame.nesting_level >= NestMax) begin
      frame = '0;
      frame.stream_closed = 1'b1;
      t.kind = jsf_pkg::KIND_OVF;
    end else begin
      frame.object_byte_count = next_len[jsf_pkg::LenW-1:0];
      t.kind = jsf_pkg::KIND_OBJ;
      if (b == jsf_pkg::ChQuote) begin
        frame.inside_string = 1'b1;
      end else if (b == jsf_pkg::ChOpen) begin
        frame.nesting_level = frame.nesting_level + 1'b1;
      end else if (b == jsf_pkg::ChClose) begin
        frame.nesting_level = frame.nesting_level - 1'b1;
        if (frame.nesting_level == '0) begin
          t.last = 1'b1;
          frame = '0;
        end
      end
    end
    return t;
  endfunction

  // Hold the byte until the transaction completes, then log its tag
  task automatic send_byte(input logic [jsf_pkg::ByteW-1:0] b, input logic nc);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= nc;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_tags.push_back(predict_tag(b, nc));
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic nc_first);
    for (int i = 0; i < s.len(); i++) send_byte(s.getc(i), nc_first && i == 0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_length_limit(input logic [jsf_pkg::LenW-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_limit = value;
    limit_writes++;
  endtask

  // Random bytes shaped by the predicted state so most traffic frames well
  task automatic random_stream(input int count);
    logic [jsf_pkg::ByteW-1:0] b;
    logic nc;
    int r;
    repeat (count) begin
      r  = $urandom_range(0, 99);
      nc = 1'b0;
      if (frame.stream_closed) nc = ($urandom_range(0, 3) == 0);
      else if ($urandom_range(0, 99) < 2) nc = 1'b1;
      if (r < 6) begin
        b = 8'($urandom_range(0, 255));
      end else if (!frame.inside_object) begin
        if (r < 60) b = jsf_pkg::ChOpen;
        else if (r < 80) b = 8'h20;
        else b = 8'($urandom_range(0, 255));
      end else if (frame.inside_string) begin
        if (frame.escape_pending) b = 8'($urandom_range(0, 255));
        else if (r < 20) b = jsf_pkg::ChQuote;
        else if (r < 30) b = jsf_pkg::ChBslash;
        else b = 8'($urandom_range(8'h20, 8'h7E));
      end else if (r < 22 && frame.nesting_level < 6) begin
        b = jsf_pkg::ChOpen;
      end else if (r < 45) begin
        b = jsf_pkg::ChClose;
      end else if (r < 55) begin
        b = jsf_pkg::ChQuote;
      end else if (r < 60) begin
        b = jsf_pkg::ChBslash;
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
      end
      send_byte(b, nc);
    end
  endtask

  task automatic test_basic_framing();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(jsf_pkg::ChClose, 1'b0);
    // braces, an escaped quote in a string, a backslash outside one
    send_text("{\"{\\\"}\"\\{}}", 1'b0);
    // escaped backslash leaves the closing quote live
    send_text("{\"\\\\\"}", 1'b0);
    // new connection in mid-object restarts framing
    send_text("{a", 1'b0);
    send_byte(jsf_pkg::ChOpen, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(jsf_pkg::ChClose, 1'b0);
  endtask

  task automatic test_length_limit();
    set_length_limit('0);
    send_byte(jsf_pkg::ChOpen, 1'b1);
    send_byte(8'h78, 1'b0);
    send_byte(jsf_pkg::ChOpen, 1'b1);
    set_length_limit(jsf_pkg::LenW'(1));
    send_byte(jsf_pkg::ChOpen, 1'b1);
    send_byte(jsf_pkg::ChClose, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h20, 1'b1);
    set_length_limit(jsf_pkg::LenW'(4));
    send_text("{ab}", 1'b1);
    send_text("{abc}", 1'b0);
    send_text("{\"ab\"", 1'b1);
    set_length_limit(jsf_pkg::LenReset);
  endtask

  task automatic test_depth_limit();
    // deepest legal nesting, a brace hidden in a string, then one level too many
    send_byte(jsf_pkg::ChOpen, 1'b1);
    repeat (NestMax - 1) send_byte(jsf_pkg::ChOpen, 1'b0);
    send_text("\"{\"", 1'b0);
    send_byte(jsf_pkg::ChOpen, 1'b0);
    send_byte(jsf_pkg::ChClose, 1'b0);
  endtask

  task automatic test_random_traffic();
    no_idle = 1'b1;
    random_stream(25);
    no_idle = 1'b0;
    random_stream(25);
    set_length_limit(20'($urandom_range(6, 40)));
    random_stream(35);
    set_length_limit(jsf_pkg::LenW'(1));
    random_stream(15);
    set_length_limit(20'($urandom_range(2, 16)));
    random_stream(25);
    set_length_limit(20'($urandom_range(17, jsf_pkg::LenReset)));
    random_stream(15);
  endtask

  // Random back-pressure on the result side
  always @(posedge clk) begin
    if (stall_left > 0 && !no_idle) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    byte_tag_exp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected result transaction, byte %h kind %0d",
                 $time, m_axis_tdata, m_axis_tuser[1:0]);
        error_count++;
      end else begin
        want = expected_tags.pop_front();
        tags_checked++;
        if (m_axis_tdata !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[1:0] !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d (byte %h)",
                   $time, want.kind, m_axis_tuser[1:0], want.data);
          error_count++;
        end
        if (m_axis_tuser[2] !== want.first) begin
          $display("%0t: first_of_object expected %b actual %b", $time, want.first,
                   m_axis_tuser[2]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_of_object expected %b actual %b", $time, want.last,
                   m_axis_tlast);
          error_count++;
        end
        if (want.last) objects_closed++;
        if (want.kind == jsf_pkg::KIND_OVF) overflow_aborts++;
      end
    end
  end

  initial begin
    frame     = '0;
    len_limit = jsf_pkg::LenReset;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_framing();
    test_length_limit();
    test_depth_limit();
    test_random_traffic();
    drain_results();
    repeat (5) @(posedge clk);
    $display("Checked %0d tags over %0d bytes: %0d objects closed, %0d overflow aborts,",
             tags_checked, bytes_sent, objects_closed, overflow_aborts);
    $display("  %0d length limit writes including zero, one and the largest value.",
             limit_writes);
    if (error_count == 0 && expected_tags.size() == 0) begin
      $display("json_object_stream_framer verification clean");
    end else begin
      $display("json_object_stream_framer verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout with %0d tags pending", $time, expected_tags.size());
    $display("json_object_stream_framer verification failed");
    $finish;
  end

endmodule

/* json_object_stream_framer.f */
design/jsf_pkg.sv
design/jsf_step.sv
design/json_object_stream_framer.sv
sim/tb_json_object_stream_framer.sv
